[src/best_fit_segment_allocator_top_defines.svh]
// Assertion macros for the best-fit segment allocator.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BFSA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BFSA_ASSERT(lbl, prop, msg)
`define BFSA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[src/bfsa_pkg.sv]
// Types, codes and constants of the best-fit segment allocator.
// No dependencies.
`default_nettype none
package bfsa_pkg;
    localparam int POOL_BLOCKS = 64;
    localparam int BLOCK_SHIFT = 14;
    localparam int ADDR_W      = $clog2(POOL_BLOCKS);

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_RESET   = 2'd2;
    localparam logic [1:0] MODE_DUMP    = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOFIT    = 2'd1;
    localparam logic [1:0] STATUS_BAD      = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] owner_id;
        logic [20:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  seg_start;
        logic [15:0] seg_owner;
        logic [6:0]  seg_blocks;
        logic [20:0] seg_bytes;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] owner;
        logic [6:0]  length;
        logic [20:0] bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_READ, ST_WALK, ST_SPLIT, ST_HEAD, ST_OUT
    } state_t;
endpackage
`default_nettype wire

[src/bfsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/best_fit_segment_allocator_top.sv]
// Reset and rejected requests go from ST_IDLE straight to ST_OUT; allocate and
// release walk the segment chain (up to 64 segments); allocate then splits.
// Dump makes one chain walk per segment reported.
// One item at a time; the shared segment RAM read port sets the walk rate.
// Reset (aresetn low, synchronous) writes the single free segment.
`default_nettype none
`include "best_fit_segment_allocator_top_defines.svh"
module best_fit_segment_allocator_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bfsa_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bfsa_pkg::out_item_t      m_data
);
    import bfsa_pkg::*;

    state_t             state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [15:0]        owner_reg, owner_next;
    logic [20:0]        bytes_reg, bytes_next;
    logic [7:0]         need_reg, need_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [6:0]         best_reg, best_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [6:0]         idx_len_reg, idx_len_next;
    logic [12:0]        prev_key_reg, prev_key_next;
    logic               have_prev_reg, have_prev_next;
    logic [12:0]        bkey_reg, bkey_next;
    logic               have_best_reg, have_best_next;
    entry_t             bent_reg, bent_next;
    logic [6:0]         count_reg, count_next;
    logic [6:0]         emitted_reg, emitted_next;
    out_item_t          out_reg, out_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             e;

    logic [7:0]  nxt, diff, tail;
    logic        at_end, fit, take, cand;
    logic [12:0] key;
    logic [6:0]  cnt_now;
    out_item_t   fail_item;

    bfsa_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_BLOCKS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    assign e       = entry_t'(ram_rdata);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
        mode_reg      <= mode_next;
        owner_reg     <= owner_next;
        bytes_reg     <= bytes_next;
        need_reg      <= need_next;
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        idx_len_reg   <= idx_len_next;
        prev_key_reg  <= prev_key_next;
        have_prev_reg <= have_prev_next;
        bkey_reg      <= bkey_next;
        have_best_reg <= have_best_next;
        bent_reg      <= bent_next;
        count_reg     <= count_next;
        emitted_reg   <= emitted_next;
        out_reg       <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        owner_next     = owner_reg;
        bytes_next     = bytes_reg;
        need_next      = need_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        idx_len_next   = idx_len_reg;
        prev_key_next  = prev_key_reg;
        have_prev_next = have_prev_reg;
        bkey_next      = bkey_reg;
        have_best_next = have_best_reg;
        bent_next      = bent_reg;
        count_next     = count_reg;
        emitted_next   = emitted_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;

        fail_item      = '0;
        fail_item.last = 1'b1;

        nxt     = {2'b00, cur_reg} + {1'b0, (e.length == 7'd0) ? 7'd1 : e.length};
        at_end  = (nxt >= 8'(POOL_BLOCKS));
        diff    = {1'b0, e.length} - need_reg;
        fit     = (e.owner == 16'd0) && ({1'b0, e.length} >= need_reg);
        take    = fit && (diff <= {1'b0, best_reg});
        key     = {e.length, cur_reg};
        cand    = (!have_prev_reg || key > prev_key_reg) && (!have_best_reg || key < bkey_reg);
        cnt_now = count_reg + 7'd1;
        tail    = {2'b00, idx_reg} + need_reg;

        unique case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{owner: 16'd0, length: 7'(POOL_BLOCKS),
                              bytes: 21'(POOL_BLOCKS) << BLOCK_SHIFT};
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next      = s_data.mode;
                    owner_next     = s_data.owner_id;
                    bytes_next     = s_data.byte_count;
                    need_next      = 8'(s_data.byte_count >> BLOCK_SHIFT)
                                   + 8'(|s_data.byte_count[BLOCK_SHIFT-1:0]);
                    cur_next       = '0;
                    best_next      = 7'(POOL_BLOCKS);
                    found_next     = 1'b0;
                    have_prev_next = 1'b0;
                    have_best_next = 1'b0;
                    count_next     = '0;
                    emitted_next   = '0;
                    state_next     = ST_READ;
                    unique case (s_data.mode)
                        MODE_ALLOC: begin
                            if (s_data.owner_id == 16'd0 || s_data.byte_count == 21'd0) begin
                                out_next        = fail_item;
                                out_next.status = STATUS_BAD;
                                state_next      = ST_OUT;
                            end
                        end
                        MODE_RELEASE: begin
                            if (s_data.owner_id == 16'd0) begin
                                out_next        = fail_item;
                                out_next.status = STATUS_BAD;
                                state_next      = ST_OUT;
                            end
                        end
                        MODE_RESET: begin
                            ram_we    = 1'b1;
                            ram_wdata = '{owner: 16'd0, length: 7'(POOL_BLOCKS),
                                          bytes: 21'(POOL_BLOCKS) << BLOCK_SHIFT};
                            out_next            = fail_item;
                            out_next.status     = STATUS_OK;
                            out_next.seg_blocks = 7'(POOL_BLOCKS);
                            out_next.seg_bytes  = 21'(POOL_BLOCKS) << BLOCK_SHIFT;
                            state_next          = ST_OUT;
                        end
                        MODE_DUMP: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cur_next   = nxt[ADDR_W-1:0];
                state_next = ST_READ;
                unique case (mode_reg)
                    MODE_ALLOC: begin
                        found_next = found_reg || fit;
                        if (take) begin
                            best_next    = diff[6:0];
                            idx_next     = cur_reg;
                            idx_len_next = e.length;
                        end
                        if ((take && diff == 8'd0) || at_end) begin
                            if (!(found_reg || fit)) begin
                                out_next        = fail_item;
                                out_next.status = STATUS_NOFIT;
                                state_next      = ST_OUT;
                            end else begin
                                state_next = ST_SPLIT;
                            end
                        end
                    end
                    MODE_RELEASE: begin
                        if (e.owner == owner_reg) begin
                            ram_we     = 1'b1;
                            ram_waddr  = cur_reg;
                            ram_wdata  = '{owner: 16'd0, length: e.length,
                                           bytes: 21'(e.length) << BLOCK_SHIFT};
                            out_next   = '{status: STATUS_OK, seg_start: cur_reg,
                                           seg_owner: owner_reg, seg_blocks: e.length,
                                           seg_bytes: 21'(e.length) << BLOCK_SHIFT,
                                           last: 1'b1};
                            state_next = ST_OUT;
                        end else if (at_end) begin
                            out_next        = fail_item;
                            out_next.status = STATUS_NOTFOUND;
                            state_next      = ST_OUT;
                        end
                    end
                    default: begin
                        count_next = cnt_now;
                        if (cand) begin
                            bkey_next      = key;
                            have_best_next = 1'b1;
                            bent_next      = e;
                        end
                        if (at_end) begin
                            out_next = '{status: STATUS_OK,
                                         seg_start: cand ? cur_reg : bkey_reg[5:0],
                                         seg_owner: cand ? e.owner : bent_reg.owner,
                                         seg_blocks: cand ? e.length : bent_reg.length,
                                         seg_bytes: cand ? e.bytes : bent_reg.bytes,
                                         last: (emitted_reg + 7'd1 == cnt_now)};
                            prev_key_next = cand ? key : bkey_reg;
                            state_next    = ST_OUT;
                        end
                    end
                endcase
            end
            ST_SPLIT: begin
                if (best_reg != 7'd0 && tail < 8'(POOL_BLOCKS)) begin
                    ram_we    = 1'b1;
                    ram_waddr = tail[ADDR_W-1:0];
                    ram_wdata = '{owner: 16'd0, length: idx_len_reg - need_reg[6:0],
                                  bytes: 21'(idx_len_reg - need_reg[6:0]) << BLOCK_SHIFT};
                end
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = '{owner: owner_reg, length: need_reg[6:0], bytes: bytes_reg};
                out_next   = '{status: STATUS_OK, seg_start: idx_reg, seg_owner: owner_reg,
                               seg_blocks: need_reg[6:0], seg_bytes: bytes_reg, last: 1'b1};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (mode_reg == MODE_DUMP && !out_reg.last) begin
                        have_prev_next = 1'b1;
                        have_best_next = 1'b0;
                        count_next     = '0;
                        emitted_next   = emitted_reg + 7'd1;
                        cur_next       = '0;
                        state_next     = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BFSA_ASSERT(a_one_side, !(s_ready && m_valid), "ready while a result is pending")
    `BFSA_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid, "result shown after reset")
    `BFSA_ASSERT(a_fail_last, (m_valid && m_data.status != STATUS_OK) |-> m_data.last, "failed item not last")
    `BFSA_ASSERT(a_multi_dump, (m_valid && !m_data.last) |-> (mode_reg == MODE_DUMP), "non-final result outside dump")
endmodule
`default_nettype wire

[tb/sv/best_fit_segment_allocator_top_tb.sv]
// Testbench for the best-fit segment allocator: directed and random requests
// checked against a behavioural pool predictor held in a scoreboard class.
// Depends on bfsa_pkg and best_fit_segment_allocator_top.
`timescale 1ns / 1ps
module best_fit_segment_allocator_top_tb;
    import bfsa_pkg::*;

    localparam int NBLK = 64;
    localparam int BLK_BYTES = 16384;

    class pool_scoreboard;
        int unsigned seg_owner_q[NBLK];
        int unsigned seg_len_q[NBLK];
        int unsigned seg_bytes_q[NBLK];
        out_item_t pending[$];
        int errors;
        int n_results;
        int n_items;

        function void clear_pool();
            for (int i = 0; i < NBLK; i++) begin
                seg_owner_q[i] = 0;
                seg_len_q[i] = 0;
                seg_bytes_q[i] = 0;
            end
            seg_len_q[0] = NBLK;
            seg_bytes_q[0] = NBLK * BLK_BYTES;
        endfunction

        function void push(logic [1:0] st, int unsigned s, int unsigned o,
                           int unsigned b, int unsigned by, bit l);
            out_item_t r;
            r.status = st;
            r.seg_start = s[5:0];
            r.seg_owner = o[15:0];
            r.seg_blocks = b[6:0];
            r.seg_bytes = by[20:0];
            r.last = l;
            pending.push_back(r);
        endfunction

        function int unsigned next_seg(int unsigned i);
            return i + (seg_len_q[i] == 0 ? 1 : seg_len_q[i]);
        endfunction

        function void note_item(in_item_t it);
            int unsigned need, best, idx, diff, t, n;
            int unsigned order[NBLK];
            int unsigned cur, q;
            bit found;
            n_items++;
            case (it.mode)
                MODE_ALLOC: begin
                    if (it.owner_id == 0 || it.byte_count == 0) begin
                        push(STATUS_BAD, 0, 0, 0, 0, 1);
                        return;
                    end
                    need = (it.byte_count + BLK_BYTES - 1) / BLK_BYTES;
                    best = NBLK;
                    idx = 0;
                    found = 0;
                    for (int unsigned i = 0; i < NBLK; i = next_seg(i)) begin
                        if (seg_owner_q[i] == 0 && seg_len_q[i] >= need) begin
                            diff = seg_len_q[i] - need;
                            found = 1;
                            if (diff <= best) begin
                                best = diff;
                                idx = i;
                                if (diff == 0) break;
                            end
                        end
                    end
                    if (!found) begin
                        push(STATUS_NOFIT, 0, 0, 0, 0, 1);
                        return;
                    end
                    if (best != 0) begin
                        t = idx + need;
                        if (t < NBLK) begin
                            seg_owner_q[t] = 0;
                            seg_len_q[t] = seg_len_q[idx] - need;
                            seg_bytes_q[t] = seg_len_q[t] * BLK_BYTES;
                        end
                    end
                    seg_owner_q[idx] = it.owner_id;
                    seg_len_q[idx] = need;
                    seg_bytes_q[idx] = it.byte_count;
                    push(STATUS_OK, idx, it.owner_id, need, it.byte_count, 1);
                end
                MODE_RELEASE: begin
                    if (it.owner_id == 0) begin
                        push(STATUS_BAD, 0, 0, 0, 0, 1);
                        return;
                    end
                    for (int unsigned i = 0; i < NBLK; i = next_seg(i)) begin
                        if (seg_owner_q[i] == it.owner_id) begin
                            seg_owner_q[i] = 0;
                            seg_bytes_q[i] = seg_len_q[i] * BLK_BYTES;
                            push(STATUS_OK, i, it.owner_id, seg_len_q[i], seg_bytes_q[i], 1);
                            return;
                        end
                    end
                    push(STATUS_NOTFOUND, 0, 0, 0, 0, 1);
                end
                MODE_RESET: begin
                    clear_pool();
                    push(STATUS_OK, 0, 0, seg_len_q[0], seg_bytes_q[0], 1);
                end
                default: begin
                    n = 0;
                    for (int unsigned i = 0; i < NBLK && n < NBLK; i = next_seg(i)) begin
                        order[n] = i;
                        n++;
                    end
                    for (int unsigned k = 1; k < n; k++) begin
                        cur = order[k];
                        q = k;
                        while (q > 0 && seg_len_q[order[q-1]] > seg_len_q[cur]) begin
                            order[q] = order[q-1];
                            q--;
                        end
                        order[q] = cur;
                    end
                    for (int unsigned k = 0; k < n; k++)
                        push(STATUS_OK, order[k], seg_owner_q[order[k]], seg_len_q[order[k]],
                             seg_bytes_q[order[k]], k + 1 == n);
                end
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            n_results++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $realtime, got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
            if (got.seg_start !== exp_r.seg_start)
                $display("%0t: seg_start exp %0d got %0d", $realtime, exp_r.seg_start,
                         got.seg_start);
            if (got.seg_owner !== exp_r.seg_owner)
                $display("%0t: seg_owner exp %0d got %0d", $realtime, exp_r.seg_owner,
                         got.seg_owner);
            if (got.seg_blocks !== exp_r.seg_blocks)
                $display("%0t: seg_blocks exp %0d got %0d", $realtime, exp_r.seg_blocks,
                         got.seg_blocks);
            if (got.seg_bytes !== exp_r.seg_bytes)
                $display("%0t: seg_bytes exp %0d got %0d", $realtime, exp_r.seg_bytes,
                         got.seg_bytes);
            if (got.last !== exp_r.last)
                $display("%0t: last exp %0d got %0d", $realtime, exp_r.last, got.last);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;

    int send_idle_pct;
    int recv_idle_pct;
    pool_scoreboard pool_sb;

    best_fit_segment_allocator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) pool_sb.check_result(m_data);
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(logic [1:0] md, logic [15:0] own, logic [20:0] nbytes);
        in_item_t it;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        it.mode = md;
        it.owner_id = own;
        it.byte_count = nbytes;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pool_sb.note_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pool_sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [20:0] rand_bytes();
        case ($urandom_range(5))
            0: return 21'($urandom_range(1, 16384));
            1: return 21'($urandom_range(1, 8) * 16384);
            2: return 21'($urandom_range(1, 300000));
            3: return 21'($urandom_range(1, 1048576));
            4: return 21'($urandom);
            default: return 21'($urandom_range(1, 65536));
        endcase
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [15:0] own;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            own = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            if (r < 50) send_item(MODE_ALLOC, own, rand_bytes());
            else if (r < 80) send_item(MODE_RELEASE, own, 21'($urandom));
            else if (r < 84) send_item(MODE_RESET, 16'($urandom), 21'($urandom));
            else if (r < 92) send_item(MODE_DUMP, 16'($urandom), 21'($urandom));
            else if (r < 96) send_item(MODE_ALLOC, 16'd0, rand_bytes());
            else send_item(MODE_ALLOC, own, 21'd0);
        end
    endtask

    initial begin
        pool_sb = new();
        pool_sb.clear_pool();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(MODE_DUMP, 16'd0, 21'd0);
        send_item(MODE_ALLOC, 16'd0, 21'd100);
        send_item(MODE_ALLOC, 16'd5, 21'd0);
        send_item(MODE_ALLOC, 16'hFFFF, 21'd1);
        send_item(MODE_ALLOC, 16'd2, 21'd16384);
        send_item(MODE_ALLOC, 16'd3, 21'd16385);
        send_item(MODE_ALLOC, 16'd4, 21'h1FFFFF);
        send_item(MODE_ALLOC, 16'd5, 21'd1048576);
        send_item(MODE_ALLOC, 16'd6, 21'd50000);
        send_item(MODE_RELEASE, 16'd0, 21'd0);
        send_item(MODE_RELEASE, 16'd999, 21'd0);
        send_item(MODE_RELEASE, 16'd3, 21'h1FFFFF);
        send_item(MODE_ALLOC, 16'd7, 21'd32768);
        send_item(MODE_DUMP, 16'hFFFF, 21'h1FFFFF);
        send_item(MODE_RESET, 16'hFFFF, 21'h1FFFFF);
        send_item(MODE_ALLOC, 16'd8, 21'd1048576);
        send_item(MODE_DUMP, 16'd0, 21'd0);
        send_item(MODE_RELEASE, 16'd8, 21'd0);
        for (int i = 0; i < 5; i++) send_item(MODE_ALLOC, 16'(10 + i), 21'd16384);
        send_item(MODE_DUMP, 16'd0, 21'd0);
        send_item(MODE_RESET, 16'd0, 21'd0);

        send_idle_pct = 17;
        recv_idle_pct = 75;
        random_phase(120);
        drain();
        send_idle_pct = 75;
        recv_idle_pct = 17;
        random_phase(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120);

        drain();
        repeat (20000) begin
            @(posedge aclk);
        end
        $display("Run covered %0d requests and %0d segment reports, incl. dumps and resets.",
                 pool_sb.n_items, pool_sb.n_results);
        if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/bfsa_pkg.sv
src/bfsa_ram.sv
src/best_fit_segment_allocator_top.sv
tb/sv/best_fit_segment_allocator_top_tb.sv
